>>> hw/rtl/assert_macros.svh
// assertion macros shared by the tag persistence filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TPF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tag persistence filter assertion failed");

// consequent checked in the cycle after the antecedent, outside reset
`define TPF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tag persistence filter assertion failed");

`endif

>>> hw/rtl/tpf_pkg.sv
// types, codes and constants of the tag persistence filter
package tpf_pkg;

   localparam int ID_W       = 8;
   localparam int CNT_W      = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam int NUM_IDS_DEFAULT = 256;

   localparam logic             WL_ENABLE_RESET  = 1'b1;
   localparam logic [CNT_W-1:0] FRAMES_REQ_RESET = 8'd2;
   localparam logic [CNT_W-1:0] CNT_MAX          = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_DETECT    = 2'd0,
      KIND_FRAME_END = 2'd1,
      KIND_WL_ADD    = 2'd2,
      KIND_WL_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WL_ENABLE  = 1'b0,
      CSR_FRAMES_REQ = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SCRUB_CLEAR = 2'd0,
      SCRUB_READ  = 2'd1,
      SCRUB_WRITE = 2'd2
   } scrub_state_type;

   // one result beat
   typedef struct packed {
      logic [ID_W-1:0]  tag_id;
      logic [CNT_W-1:0] hit_count;
      logic             frame_end;
   } rsp_type;

   // scrubber status toward the item path
   typedef struct packed {
      logic clearing;
      logic block;
   } scrub_stat_type;

   // output buffer status toward the item path
   typedef struct packed {
      logic       room;
      logic [1:0] count;
   } obuf_stat_type;

endpackage

>>> hw/rtl/tag_persistence_filter.sv
// top level of the tag persistence filter: item stage, id table, scrubber and result buffer
//
//   channel  ports                                   direction  beat
//   req      req_valid req_ready req_kind req_tag_id  in         one marker item
//   rsp      rsp_valid rsp_ready rsp_tag_id_res ...   out        reported id or frame marker
//   csr      csr_valid csr_ready csr_index csr_wdata  in         one register write
//
// An item is registered with its table word, updated in the next cycle and its result
// pushed to a two-entry buffer: up to one item per cycle while req_ready is high. After
// reset a clearing pass over all NUM_IDS entries fills the table; req_ready is low
// meanwhile. The table's single write port is shared with a stamp scrubber; when both
// need it for different entries, req_ready drops for one cycle. req_ready also drops
// when the result buffer would hold two results after this cycle.
`include "assert_macros.svh"

module tag_persistence_filter import tpf_pkg::*; #(
   parameter int NUM_IDS = NUM_IDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [ID_W-1:0]       req_tag_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ID_W-1:0]       rsp_tag_id_res,
   output logic [CNT_W-1:0]      rsp_hit_count,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(NUM_IDS);
   localparam int SW = AW + 3;
   localparam int DW = 2 * SW + CNT_W;
   localparam int XW = ((AW > ID_W) ? AW : ID_W) + 1;

   // configuration
   logic             wl_enable_ff;
   logic [CNT_W-1:0] frames_req_ff;

   // epochs and list state
   logic [SW-1:0] frame_ep_ff, frame_ep_in;
   logic [SW-1:0] wl_ep_ff, wl_ep_in;
   logic          wl_nonempty_ff, wl_nonempty_in;

   // item stage
   logic            req_accept;
   logic            req_in_range;
   logic            stage_valid_ff;
   kind_type        stage_kind_ff;
   logic [ID_W-1:0] stage_id_ff;
   logic            stage_inr_ff;
   logic [AW-1:0]   stage_addr;

   // table access
   logic [DW-1:0] item_rd_data;
   logic [DW-1:0] scrub_rd_data;
   logic          scrub_rd_en;
   logic [AW-1:0] scrub_rd_addr;
   logic          scrub_wr_en;
   logic [AW-1:0] scrub_wr_addr;
   logic [DW-1:0] scrub_wr_data;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [DW-1:0] mem_wr_data;
   scrub_stat_type scrub_stat;

   // update logic
   logic [SW-1:0]    wst, fst, fage;
   logic [CNT_W-1:0] cnt;
   logic             seen_this, seen_last, listed, filtered;
   logic             det_ok, report;
   logic [CNT_W-1:0] hits, need;
   logic             stage_wr;
   logic [DW-1:0]    stage_wr_data;
   logic             stage_push;
   rsp_type          stage_rsp;

   // result buffer
   rsp_type       rsp_data;
   obuf_stat_type obuf_stat;

   // configuration writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_enable_ff  <= WL_ENABLE_RESET;
         frames_req_ff <= FRAMES_REQ_RESET;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_WL_ENABLE:  wl_enable_ff  <= csr_wdata[0];
            CSR_FRAMES_REQ: frames_req_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_ready    = !scrub_stat.clearing && !scrub_stat.block && obuf_stat.room;
   assign req_accept   = req_valid && req_ready;
   assign req_in_range = (XW'(req_tag_id) < XW'(NUM_IDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff <= kind_type'(req_kind);
         stage_id_ff   <= req_tag_id;
         stage_inr_ff  <= req_in_range;
      end
   end

   assign stage_addr = AW'(stage_id_ff);

   // per-id table
   tpf_tag_mem #(.NUM_IDS(NUM_IDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .a_en    (req_accept && req_in_range),
      .a_addr  (AW'(req_tag_id)),
      .a_data  (item_rd_data),
      .b_en    (scrub_rd_en),
      .b_addr  (scrub_rd_addr),
      .b_data  (scrub_rd_data)
   );

   tpf_scrub #(.NUM_IDS(NUM_IDS)) u_scrub (
      .clock      (clock),
      .reset      (reset),
      .frame_ep   (frame_ep_ff),
      .wl_ep      (wl_ep_ff),
      .stage_wr   (stage_wr),
      .stage_addr (stage_addr),
      .rd_data    (scrub_rd_data),
      .rd_en      (scrub_rd_en),
      .rd_addr    (scrub_rd_addr),
      .wr_en      (scrub_wr_en),
      .wr_addr    (scrub_wr_addr),
      .wr_data    (scrub_wr_data),
      .stat       (scrub_stat)
   );

   // write port: the item stage wins
   assign mem_wr_en   = stage_wr || scrub_wr_en;
   assign mem_wr_addr = stage_wr ? stage_addr : scrub_wr_addr;
   assign mem_wr_data = stage_wr ? stage_wr_data : scrub_wr_data;

   // frame and list membership from stamps against the current epochs
   always_comb begin
      wst       = item_rd_data[DW-1 -: SW];
      fst       = item_rd_data[SW+CNT_W-1 -: SW];
      cnt       = item_rd_data[CNT_W-1:0];
      fage      = frame_ep_ff - fst;
      seen_this = (fage == SW'(0));
      seen_last = (fage == SW'(1));
      listed    = (wst == wl_ep_ff);
      filtered  = wl_enable_ff && wl_nonempty_ff && !listed;
   end

   // detection update and report decision
   always_comb begin
      det_ok = (stage_kind_ff == KIND_DETECT) && stage_inr_ff && !filtered && !seen_this;
      if (!seen_last) begin
         hits = CNT_W'(1);
      end else if (cnt == CNT_MAX) begin
         hits = cnt;
      end else begin
         hits = cnt + CNT_W'(1);
      end
      need   = (frames_req_ff == '0) ? CNT_W'(1) : frames_req_ff;
      report = det_ok && (hits >= need);
   end

   // table write back, stale stamps normalized
   always_comb begin
      logic [SW-1:0]    wst_n;
      logic [SW-1:0]    fst_n;
      logic [CNT_W-1:0] cnt_n;
      stage_wr = stage_valid_ff && stage_inr_ff &&
                 ((stage_kind_ff == KIND_DETECT) || (stage_kind_ff == KIND_WL_ADD));
      if (stage_kind_ff == KIND_WL_ADD) begin
         wst_n = wl_ep_ff;
      end else begin
         wst_n = listed ? wst : (wl_ep_ff - SW'(1));
      end
      if (det_ok) begin
         fst_n = frame_ep_ff;
         cnt_n = hits;
      end else begin
         fst_n = (fage > SW'(1)) ? (frame_ep_ff - SW'(2)) : fst;
         cnt_n = cnt;
      end
      stage_wr_data = {wst_n, fst_n, cnt_n};
   end

   // result beat
   always_comb begin
      stage_push = stage_valid_ff && (report || (stage_kind_ff == KIND_FRAME_END));
      if (stage_kind_ff == KIND_FRAME_END) begin
         stage_rsp.tag_id    = '0;
         stage_rsp.hit_count = '0;
         stage_rsp.frame_end = 1'b1;
      end else begin
         stage_rsp.tag_id    = stage_id_ff;
         stage_rsp.hit_count = hits;
         stage_rsp.frame_end = 1'b0;
      end
   end

   // epochs: frame end rolls the frame flags, list clear empties the list
   always_comb begin
      frame_ep_in    = frame_ep_ff;
      wl_ep_in       = wl_ep_ff;
      wl_nonempty_in = wl_nonempty_ff;
      if (stage_valid_ff) begin
         case (stage_kind_ff)
            KIND_FRAME_END: frame_ep_in = frame_ep_ff + SW'(1);
            KIND_WL_CLEAR: begin
               wl_ep_in       = wl_ep_ff + SW'(1);
               wl_nonempty_in = 1'b0;
            end
            KIND_WL_ADD: begin
               if (stage_inr_ff) begin
                  wl_nonempty_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ep_ff    <= '0;
         wl_ep_ff       <= '0;
         wl_nonempty_ff <= 1'b0;
      end else begin
         frame_ep_ff    <= frame_ep_in;
         wl_ep_ff       <= wl_ep_in;
         wl_nonempty_ff <= wl_nonempty_in;
      end
   end

   tpf_out_buf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (stage_push),
      .push_data (stage_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .stat      (obuf_stat)
   );

   assign rsp_tag_id_res = rsp_data.tag_id;
   assign rsp_hit_count  = rsp_data.hit_count;
   assign rsp_frame_end  = rsp_data.frame_end;

   // checks
   `TPF_ASSERT(a_no_item_in_clear, clock, reset, scrub_stat.clearing |-> !req_ready)
   `TPF_ASSERT(a_one_writer, clock, reset, !(stage_wr && scrub_wr_en))
   `TPF_ASSERT(a_obuf_no_overflow, clock, reset, stage_push |-> ((obuf_stat.count < 2'd2) || rsp_ready))
   `TPF_ASSERT_NEXT(a_block_frees_port, clock, reset, scrub_stat.block, !stage_valid_ff)

endmodule

>>> hw/rtl/tpf_tag_mem.sv
// per-id table memory: one write port, two registered read ports with write forwarding
module tpf_tag_mem import tpf_pkg::*; #(
   parameter int NUM_IDS = NUM_IDS_DEFAULT,
   localparam int AW = $clog2(NUM_IDS),
   localparam int DW = 2 * (AW + 3) + CNT_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          a_en,
   input  logic [AW-1:0] a_addr,
   output logic [DW-1:0] a_data,
   input  logic          b_en,
   input  logic [AW-1:0] b_addr,
   output logic [DW-1:0] b_data
);

   logic [DW-1:0] mem [NUM_IDS];
   logic [DW-1:0] a_data_ff;
   logic [DW-1:0] b_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, a same-cycle write to the address is passed through
   always_ff @(posedge clock) begin
      if (a_en) begin
         a_data_ff <= (wr_en && (wr_addr == a_addr)) ? wr_data : mem[a_addr];
      end
      if (b_en) begin
         b_data_ff <= (wr_en && (wr_addr == b_addr)) ? wr_data : mem[b_addr];
      end
   end

   assign a_data = a_data_ff;
   assign b_data = b_data_ff;

endmodule

>>> hw/rtl/tpf_scrub.sv
// reset clearing pass and background stamp scrubber for the id table
module tpf_scrub import tpf_pkg::*; #(
   parameter int NUM_IDS = NUM_IDS_DEFAULT,
   localparam int AW = $clog2(NUM_IDS),
   localparam int SW = AW + 3,
   localparam int DW = 2 * SW + CNT_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [SW-1:0]  frame_ep,
   input  logic [SW-1:0]  wl_ep,
   input  logic           stage_wr,
   input  logic [AW-1:0]  stage_addr,
   input  logic [DW-1:0]  rd_data,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr,
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic [DW-1:0]  wr_data,
   output scrub_stat_type stat
);

   scrub_state_type state_ff, state_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic            ptr_last;
   logic [SW-1:0]   wst, fst, fage;
   logic [CNT_W-1:0] cnt;
   logic [SW-1:0]   wst_n, fst_n;

   assign ptr_last = (ptr_ff == AW'(NUM_IDS - 1));

   // stale stamps are pulled back to a fixed distance behind the epochs
   always_comb begin
      wst   = rd_data[DW-1 -: SW];
      fst   = rd_data[SW+CNT_W-1 -: SW];
      cnt   = rd_data[CNT_W-1:0];
      fage  = frame_ep - fst;
      fst_n = (fage > SW'(1)) ? (frame_ep - SW'(2)) : fst;
      wst_n = (wst == wl_ep) ? wst : (wl_ep - SW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCRUB_CLEAR;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   // sweep sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = {wst_n, fst_n, cnt};
      stat.clearing = 1'b0;
      stat.block    = 1'b0;
      case (state_ff)
         SCRUB_CLEAR: begin
            stat.clearing = 1'b1;
            wr_en         = 1'b1;
            wr_data       = {wl_ep - SW'(1), frame_ep - SW'(2), CNT_W'(0)};
            ptr_in        = ptr_last ? '0 : ptr_ff + AW'(1);
            if (ptr_last) begin
               state_in = SCRUB_READ;
            end
         end
         SCRUB_READ: begin
            rd_en    = 1'b1;
            state_in = SCRUB_WRITE;
         end
         SCRUB_WRITE: begin
            if (stage_wr && (stage_addr != ptr_ff)) begin
               // write port busy: hold off new items for one cycle and retry
               stat.block = 1'b1;
            end else begin
               // a stage write to this entry leaves it fresh already
               wr_en    = !stage_wr;
               ptr_in   = ptr_last ? '0 : ptr_ff + AW'(1);
               state_in = SCRUB_READ;
            end
         end
         default: begin
            state_in = SCRUB_CLEAR;
            ptr_in   = '0;
         end
      endcase
   end

   assign rd_addr = ptr_ff;
   assign wr_addr = ptr_ff;

endmodule

>>> hw/rtl/tpf_out_buf.sv
// two-entry result buffer between the update stage and the result channel
module tpf_out_buf import tpf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_type       push_data,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_type       out_data,
   output obuf_stat_type stat
);

   rsp_type    data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [2:0] fill_next;

   assign pop       = (count_ff != 2'd0) && out_ready;
   assign fill_next = 3'(count_ff) + 3'(push) - 3'(pop);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = fill_next[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid  = (count_ff != 2'd0);
   assign out_data   = data_ff[rd_ptr_ff];
   // room for one more item in flight after this cycle
   assign stat.room  = (fill_next <= 3'd1);
   assign stat.count = count_ff;

endmodule

>>> tb/tb.sv
// testbench for the tag persistence filter: random stalls on both channels, predicted results
module tb;
   import tpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_IDS      = NUM_IDS_DEFAULT;
   localparam int SETTLE_WAIT  = 8;
   localparam int QUIET_LIMIT  = 2000;

   // one pending input beat
   typedef struct {
      kind_type         kind;
      logic [ID_W-1:0]  tag_id;
   } marker_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind = KIND_DETECT;
   logic [ID_W-1:0]       req_tag_id = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ID_W-1:0]       rsp_tag_id_res;
   logic [CNT_W-1:0]      rsp_hit_count;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WL_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the filter state and its registers
   logic                  filt_en     = WL_ENABLE_RESET;
   logic [CNT_W-1:0]      need_frames = FRAMES_REQ_RESET;
   bit [NUM_IDS-1:0]      allow_list  = '0;
   bit                    allow_any   = 1'b0;
   bit [NUM_IDS-1:0]      seen_now    = '0;
   bit [NUM_IDS-1:0]      seen_prev   = '0;
   logic [CNT_W-1:0]      streak [NUM_IDS] = '{default: '0};

   marker_item_type       item_fifo [$];
   rsp_type               report_q [$];
   int unsigned           mismatches = 0;
   int unsigned           req_hold   = 0;
   int unsigned           req_calm   = 0;
   int unsigned           rsp_hold   = 0;
   int unsigned           rsp_calm   = 0;
   int unsigned           quiet      = 0;

   tag_persistence_filter #(.NUM_IDS(NUM_IDS)) dut (.*);

   always #4ns clock = ~clock;

   // wait before a beat: mostly a random gap, with runs of back-to-back beats
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0)
         calm = $urandom_range(8, 40);
      return $urandom_range(0, 15);
   endfunction

   // random marker id
   function automatic logic [ID_W-1:0] rand_id();
      return ID_W'($urandom_range(0, 255));
   endfunction

   // update the shadow state for one accepted item, queue its report if any
   function automatic void track_item(kind_type kind, logic [ID_W-1:0] id);
      rsp_type          res;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] need;
      case (kind)
         KIND_FRAME_END: begin
            seen_prev = seen_now;
            seen_now  = '0;
            res.tag_id    = '0;
            res.hit_count = '0;
            res.frame_end = 1'b1;
            report_q = {report_q, res};
         end
         KIND_WL_CLEAR: begin
            allow_list = '0;
            allow_any  = 1'b0;
         end
         KIND_WL_ADD: begin
            // ids outside the table are ignored
            if (int'(id) < NUM_IDS) begin
               allow_list[id] = 1'b1;
               allow_any      = 1'b1;
            end
         end
         default: begin
            // table range, whitelist filter, then one acceptance per id and frame
            if ((int'(id) < NUM_IDS) && !(filt_en && allow_any && !allow_list[id]) &&
                !seen_now[id]) begin
               seen_now[id] = 1'b1;
               if (!seen_prev[id])
                  hits = CNT_W'(1);
               else if (streak[id] == CNT_MAX)
                  hits = CNT_MAX;
               else
                  hits = streak[id] + CNT_W'(1);
               streak[id] = hits;
               need = (need_frames == '0) ? CNT_W'(1) : need_frames;
               if (hits >= need) begin
                  res.tag_id    = id;
                  res.hit_count = hits;
                  res.frame_end = 1'b0;
                  report_q = {report_q, res};
               end
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // request driver: one item per beat, random gap before each
   always @(posedge clock) begin : req_driver
      marker_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_valid && req_ready)
            track_item(kind_type'(req_kind), req_tag_id);
         if (!req_valid || req_ready) begin
            if (req_hold != 0) begin
               req_hold--;
               req_valid <= 1'b0;
            end else if (item_fifo.size() != 0) begin
               nxt = item_fifo.pop_front();
               req_valid  <= 1'b1;
               req_kind   <= nxt.kind;
               req_tag_id <= nxt.tag_id;
               req_hold = draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each beat with the oldest prediction, then stall at random
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual id %0d count %0d end %0d",
                        $time, rsp_tag_id_res, rsp_hit_count, rsp_frame_end);
               mismatches++;
            end else begin
               want = report_q.pop_front();
               check_field("tag_id_res", 32'(want.tag_id), 32'(rsp_tag_id_res));
               check_field("hit_count", 32'(want.hit_count), 32'(rsp_hit_count));
               check_field("frame_end", 32'(want.frame_end), 32'(rsp_frame_end));
            end
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic queue_item(kind_type kind, logic [ID_W-1:0] id);
      marker_item_type it;
      it.kind   = kind;
      it.tag_id = id;
      item_fifo = {item_fifo, it};
   endtask

   // wait until every item is in and every report is out, then let the pipe empty;
   // sampled mid-cycle so the driver's updates at the edge are already visible
   task automatic settle();
      @(negedge clock);
      while (item_fifo.size() != 0 || req_valid || report_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // write both registers back to back while the filter is idle
   task automatic set_mode(logic en, logic [CSR_DATA_W-1:0] frames);
      csr_valid <= 1'b1;
      csr_index <= CSR_WL_ENABLE;
      csr_wdata <= CSR_DATA_W'(en);
      do @(posedge clock); while (!csr_ready);
      filt_en = en;
      csr_index <= CSR_FRAMES_REQ;
      csr_wdata <= frames;
      do @(posedge clock); while (!csr_ready);
      need_frames = frames;
      csr_valid <= 1'b0;
   endtask

   // frames of detections from a small drifting id pool, with list edits and noise
   task automatic random_items(int unsigned count);
      logic [ID_W-1:0] pool [3];
      int unsigned     roll;
      foreach (pool[i]) pool[i] = rand_id();
      repeat (count) begin
         if ($urandom_range(0, 39) == 0)
            pool[$urandom_range(0, 2)] = rand_id();
         roll = $urandom_range(0, 99);
         if (roll < 4)
            queue_item(KIND_WL_CLEAR, rand_id());
         else if (roll < 11)
            queue_item(KIND_WL_ADD, pool[$urandom_range(0, 2)]);
         else if (roll < 14)
            queue_item(KIND_WL_ADD, rand_id());
         else if (roll < 34)
            queue_item(KIND_FRAME_END, rand_id());
         else if (roll < 82)
            queue_item(KIND_DETECT, pool[$urandom_range(0, 2)]);
         else
            queue_item(KIND_DETECT, rand_id());
      end
   endtask

   initial begin
      logic [ID_W-1:0] keep;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first hits, duplicates, missed frame, list add and clear
      queue_item(KIND_DETECT, 8'd0);
      queue_item(KIND_DETECT, 8'd255);
      queue_item(KIND_DETECT, 8'd0);
      queue_item(KIND_FRAME_END, 8'd255);
      queue_item(KIND_DETECT, 8'd0);
      queue_item(KIND_DETECT, 8'd255);
      queue_item(KIND_FRAME_END, 8'd0);
      queue_item(KIND_FRAME_END, 8'd0);
      queue_item(KIND_DETECT, 8'd0);
      queue_item(KIND_WL_ADD, 8'd5);
      queue_item(KIND_WL_ADD, 8'd255);
      queue_item(KIND_DETECT, 8'd7);
      queue_item(KIND_DETECT, 8'd255);
      queue_item(KIND_DETECT, 8'd5);
      queue_item(KIND_FRAME_END, 8'd0);
      queue_item(KIND_DETECT, 8'd255);
      queue_item(KIND_WL_CLEAR, 8'hAA);
      queue_item(KIND_DETECT, 8'd7);
      queue_item(KIND_DETECT, 8'd0);
      queue_item(KIND_FRAME_END, 8'd0);
      settle();

      // zero required count behaves as one
      set_mode(1'b1, 8'd0);
      queue_item(KIND_DETECT, 8'd7);
      queue_item(KIND_DETECT, 8'd9);
      queue_item(KIND_FRAME_END, 8'd0);
      random_items(100);
      settle();

      // filtering off, every accepted id reported
      set_mode(1'b0, 8'd1);
      random_items(100);
      settle();

      set_mode(1'b1, 8'd3);
      random_items(100);
      settle();

      // one id held across many frames, long streaks
      set_mode(1'b1, 8'd30);
      keep = rand_id();
      queue_item(KIND_WL_ADD, keep);
      repeat (40) begin
         queue_item(KIND_DETECT, keep);
         if ($urandom_range(0, 3) == 0)
            queue_item(KIND_DETECT, rand_id());
         queue_item(KIND_FRAME_END, 8'd0);
      end
      settle();

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
